FILE: rtl/rgbhsl_pkg.sv
// Shared types, constants and the divider step function for the RGB to HSL converter.
// Used by every module of the converter; it depends on nothing else.
`default_nettype none
package rgbhsl_pkg;

   localparam int CHAN_W         = 8;   // one color channel
   localparam int HUE_W          = 9;   // hue in degrees, 0..359
   localparam int NUM_W          = 18;  // divider dividend
   localparam int DEN_W          = 9;   // divider divisor
   localparam int QUO_W          = 8;   // divider quotient
   localparam int QIDX_W         = $clog2(QUO_W);
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
   localparam int HSUM_W         = 10;  // hue before wrapping, up to 600

   localparam logic [HSUM_W-1:0] HUE_FULL       = HSUM_W'(360);
   localparam logic [HSUM_W-1:0] HUE_BASE_RED   = HSUM_W'(0);
   localparam logic [HSUM_W-1:0] HUE_BASE_GREEN = HSUM_W'(120);
   localparam logic [HSUM_W-1:0] HUE_BASE_BLUE  = HSUM_W'(240);

   // Which channel holds the maximum; ties go to red, then green.
   typedef enum logic [1:0] {
      SECT_RED   = 2'd0,
      SECT_GREEN = 2'd1,
      SECT_BLUE  = 2'd2
   } sector_type;

   // Control and small payload that travel beside the divider pipeline.
   typedef struct packed {
      logic              valid;
      logic              grey;
      logic              neg;
      sector_type        sector;
      logic [CHAN_W-1:0] light;
   } side_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_op_type;

   typedef struct packed {
      side_type   side;
      div_op_type sat_op;
      div_op_type hue_op;
   } front_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
   } div_state_type;

   // One restoring division step for quotient bit number idx.
   function automatic div_state_type div_step(input div_state_type s,
                                              input logic [QIDX_W-1:0] idx);
      logic [NUM_W-1:0] trial;
      div_state_type    r;
      trial = NUM_W'(s.den) << idx;
      r     = s;
      if (s.rem >= trial) begin
         r.rem      = s.rem - trial;
         r.quo[idx] = 1'b1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/rgbhsl_front.sv
// Front end of the RGB to HSL converter: channel extremes, then divider operands.
// Two register stages; depends on rgbhsl_pkg.
`default_nettype none
module rgbhsl_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [rgbhsl_pkg::CHAN_W-1:0] red,
   input  wire logic [rgbhsl_pkg::CHAN_W-1:0] green,
   input  wire logic [rgbhsl_pkg::CHAN_W-1:0] blue,
   output rgbhsl_pkg::front_type          out
);
   import rgbhsl_pkg::*;

   // Stage 1 registers.
   logic              valid1_ff;
   logic [CHAN_W-1:0] mx_ff, mn_ff, diff_ff;
   logic [CHAN_W-1:0] mx_in, mn_in, diff_in;
   logic              neg_ff, neg_in;
   sector_type        sector_ff, sector_in;

   // Stage 2 register.
   front_type         out_ff, out_in;

   logic [CHAN_W-1:0] pos, negv;

   always_comb begin
      if (red >= green && red >= blue) begin
         sector_in = SECT_RED;
         mx_in     = red;
         pos       = green;
         negv      = blue;
      end else if (green >= blue) begin
         sector_in = SECT_GREEN;
         mx_in     = green;
         pos       = blue;
         negv      = red;
      end else begin
         sector_in = SECT_BLUE;
         mx_in     = blue;
         pos       = red;
         negv      = green;
      end
      mn_in = red;
      if (green < mn_in) begin
         mn_in = green;
      end
      if (blue < mn_in) begin
         mn_in = blue;
      end
      neg_in  = pos < negv;
      diff_in = neg_in ? (negv - pos) : (pos - negv);
   end

   logic [CHAN_W:0]   sum;
   logic [CHAN_W-1:0] delta, den;

   always_comb begin
      sum   = {1'b0, mx_ff} + {1'b0, mn_ff};
      delta = mx_ff - mn_ff;
      if (sum <= (CHAN_W+1)'(255)) begin
         den = sum[CHAN_W-1:0];
      end else begin
         den = CHAN_W'((CHAN_W+1)'(510) - sum);
      end
      out_in.side.valid  = valid1_ff;
      out_in.side.grey   = (delta == '0);
      out_in.side.neg    = neg_ff;
      out_in.side.sector = sector_ff;
      out_in.side.light  = CHAN_W'((sum + (CHAN_W+1)'(1)) >> 1);
      // Saturation: (510*delta + den) / (2*den), rounding half up.
      out_in.sat_op.num  = (NUM_W'(delta) << 9) - (NUM_W'(delta) << 1) + NUM_W'(den);
      out_in.sat_op.den  = {den, 1'b0};
      // Hue term magnitude: (120*n + delta) / (2*delta).
      out_in.hue_op.num  = (NUM_W'(diff_ff) << 7) - (NUM_W'(diff_ff) << 3) + NUM_W'(delta);
      out_in.hue_op.den  = {delta, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff     <= mx_in;
         mn_ff     <= mn_in;
         diff_ff   <= diff_in;
         neg_ff    <= neg_in;
         sector_ff <= sector_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.side.valid <= 1'b0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

   assign out = out_ff;

endmodule
`default_nettype wire

FILE: rtl/rgbhsl_div.sv
// Pipelined restoring divider, two quotient bits per register stage.
// The quotient must be known to fit in eight bits; depends on rgbhsl_pkg.
`default_nettype none
module rgbhsl_div (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  rgbhsl_pkg::div_op_type        op,
   output logic [rgbhsl_pkg::QUO_W-1:0]  quo
);
   import rgbhsl_pkg::*;

   div_state_type stage_ff [DIV_STAGES];
   div_state_type stage_in [DIV_STAGES];
   div_state_type prev     [DIV_STAGES];

   assign prev[0] = '{rem: op.num, den: op.den, quo: '0};

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      if (s > 0) begin : g_link
         assign prev[s] = stage_ff[s-1];
      end

      always_comb begin
         div_state_type st;
         st = prev[s];
         for (int k = 0; k < BITS_PER_STAGE; k++) begin
            st = div_step(st, QIDX_W'(QUO_W - 1 - BITS_PER_STAGE * s - k));
         end
         stage_in[s] = st;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign quo = stage_ff[DIV_STAGES-1].quo;

endmodule
`default_nettype wire

FILE: rtl/rgbhsl_back.sv
// Back end of the RGB to HSL converter: hue assembly, wrap, grey override, output register.
// Depends on rgbhsl_pkg.
`default_nettype none
module rgbhsl_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  rgbhsl_pkg::side_type               side,
   input  wire logic [rgbhsl_pkg::QUO_W-1:0]  sat_q,
   input  wire logic [rgbhsl_pkg::QUO_W-1:0]  hue_q,
   output logic                               out_valid,
   output logic [rgbhsl_pkg::HUE_W-1:0]       hue,
   output logic [rgbhsl_pkg::CHAN_W-1:0]      saturation,
   output logic [rgbhsl_pkg::CHAN_W-1:0]      lightness
);
   import rgbhsl_pkg::*;

   logic              valid_ff;
   logic [HUE_W-1:0]  hue_ff, hue_in;
   logic [CHAN_W-1:0] sat_ff, sat_in;
   logic [CHAN_W-1:0] light_ff;

   logic [HSUM_W-1:0] base, h;

   always_comb begin
      case (side.sector)
         SECT_RED:   base = HUE_BASE_RED;
         SECT_GREEN: base = HUE_BASE_GREEN;
         SECT_BLUE:  base = HUE_BASE_BLUE;
         default:    base = HUE_BASE_RED;
      endcase
      // A negative term borrows a full turn, then the wrap folds 360 and above back.
      if (side.neg) begin
         h = base + HUE_FULL - HSUM_W'(hue_q);
      end else begin
         h = base + HSUM_W'(hue_q);
      end
      if (h >= HUE_FULL) begin
         h = h - HUE_FULL;
      end
      if (side.grey) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         hue_in = h[HUE_W-1:0];
         sat_in = sat_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         light_ff <= side.light;
      end
   end

   assign out_valid  = valid_ff;
   assign hue        = hue_ff;
   assign saturation = sat_ff;
   assign lightness  = light_ff;

endmodule
`default_nettype wire

FILE: rtl/rgb_to_hsl_convert.sv
// Top level of the RGB to HSL converter: front end, two dividers, side pipeline, back end.
// Depends on rgbhsl_pkg, rgbhsl_front, rgbhsl_div and rgbhsl_back.
//
// Usage:
//   A pixel enters on the req_ channel (req_red, req_green, req_blue) as one
//   valid/ready transaction. Its hue, saturation and lightness leave on the
//   rsp_ channel as exactly one transaction, in the order the pixels came in.
//   No state links one pixel to the next.
// Pipeline and throughput:
//   The pipeline has seven register stages: two front-end stages (extremes,
//   then operands), four divider stages at two quotient bits each, and the
//   output register. The accepting edge loads the first stage, and a result
//   shows on rsp_valid when the output register takes it. The saturation
//   and hue dividers run side by side. One pixel is accepted every cycle
//   while the receiver keeps rsp_ready high.
// Reset:
//   The synchronous reset clears every valid bit in the pipeline, so no
//   result leaves until a new pixel has passed through.
// Stalls:
//   When a result waits with rsp_ready low, the whole pipeline holds and
//   req_ready drops; nothing is dropped or repeated. req_ready is high
//   whenever the output register is empty or is being emptied that cycle.
`default_nettype none
module rgb_to_hsl_convert (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [rgbhsl_pkg::CHAN_W-1:0] req_red,
   input  wire logic [rgbhsl_pkg::CHAN_W-1:0] req_green,
   input  wire logic [rgbhsl_pkg::CHAN_W-1:0] req_blue,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [rgbhsl_pkg::HUE_W-1:0]       rsp_hue,
   output logic [rgbhsl_pkg::CHAN_W-1:0]      rsp_saturation,
   output logic [rgbhsl_pkg::CHAN_W-1:0]      rsp_lightness
);
   import rgbhsl_pkg::*;

   // The pipeline advances as one unit whenever the output slot can take data.
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   front_type front;

   rgbhsl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .red      (req_red),
      .green    (req_green),
      .blue     (req_blue),
      .out      (front)
   );

   logic [QUO_W-1:0] sat_q, hue_q;

   rgbhsl_div u_sat_div (
      .clock (clock),
      .en    (en),
      .op    (front.sat_op),
      .quo   (sat_q)
   );

   rgbhsl_div u_hue_div (
      .clock (clock),
      .en    (en),
      .op    (front.hue_op),
      .quo   (hue_q)
   );

   // The sector, sign, grey flag, lightness and valid bit travel beside the
   // divider stages so that they meet the quotients at the back end.
   side_type side_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         side_ff[0] <= front.side;
         for (int i = 1; i < DIV_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   rgbhsl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .side       (side_ff[DIV_STAGES-1]),
      .sat_q      (sat_q),
      .hue_q      (hue_q),
      .out_valid  (rsp_valid),
      .hue        (rsp_hue),
      .saturation (rsp_saturation),
      .lightness  (rsp_lightness)
   );

endmodule
`default_nettype wire

FILE: tb/sv/rgbhsl_checker.sv
// Checker for the RGB to HSL converter: watches both channels and predicts each result.
// It compares the results in order, field by field. Depends on rgbhsl_pkg.
module rgbhsl_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic [rgbhsl_pkg::CHAN_W-1:0] req_red,
   input  wire logic [rgbhsl_pkg::CHAN_W-1:0] req_green,
   input  wire logic [rgbhsl_pkg::CHAN_W-1:0] req_blue,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [rgbhsl_pkg::HUE_W-1:0]  rsp_hue,
   input  wire logic [rgbhsl_pkg::CHAN_W-1:0] rsp_saturation,
   input  wire logic [rgbhsl_pkg::CHAN_W-1:0] rsp_lightness,
   output int                                 fail_count,
   output int                                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rgbhsl_pkg::*;

   typedef struct packed {
      logic [3*CHAN_W-1:0] rgb;
      logic [HUE_W-1:0]    hue;
      logic [CHAN_W-1:0]   sat;
      logic [CHAN_W-1:0]   light;
   } hsl_pixel_type;

   hsl_pixel_type expected_hsl_q[$];
   int failures = 0;
   int pending_n = 0;

   assign fail_count    = failures;
   assign pending_count = pending_n;

   task automatic report_failure(input string msg);
      $display("%0t ns: %s", $time, msg);
      failures++;
   endtask

   // Integer hexcone conversion of one pixel.
   function automatic hsl_pixel_type hsl_of_rgb(input logic [CHAN_W-1:0] r,
                                                input logic [CHAN_W-1:0] g,
                                                input logic [CHAN_W-1:0] b);
      int top, bottom, sum, delta, den, sat, base, lead, lag, mag, hue;
      sector_type sect;
      hsl_pixel_type px;
      top = int'(r);
      bottom = int'(r);
      if (int'(g) > top) top = int'(g);
      if (int'(b) > top) top = int'(b);
      if (int'(g) < bottom) bottom = int'(g);
      if (int'(b) < bottom) bottom = int'(b);
      sum   = top + bottom;
      delta = top - bottom;
      sat   = 0;
      hue   = 0;
      if (delta != 0) begin
         den = (sum <= 255) ? sum : 510 - sum;
         if (den != 0) sat = (2 * 255 * delta + den) / (2 * den);
         if (sat > 255) sat = 255;
         if (top == int'(r)) sect = SECT_RED;
         else if (top == int'(g)) sect = SECT_GREEN;
         else sect = SECT_BLUE;
         case (sect)
            SECT_RED: begin
               base = int'(HUE_BASE_RED);
               lead = int'(g);
               lag  = int'(b);
            end
            SECT_GREEN: begin
               base = int'(HUE_BASE_GREEN);
               lead = int'(b);
               lag  = int'(r);
            end
            default: begin
               base = int'(HUE_BASE_BLUE);
               lead = int'(r);
               lag  = int'(g);
            end
         endcase
         // The magnitude is rounded half away from zero, then the sign goes back on.
         if (lead >= lag) begin
            mag = (120 * (lead - lag) + delta) / (2 * delta);
            hue = base + mag;
         end else begin
            mag = (120 * (lag - lead) + delta) / (2 * delta);
            hue = base - mag;
         end
         if (hue < 0) hue += int'(HUE_FULL);
         if (hue >= int'(HUE_FULL)) hue -= int'(HUE_FULL);
      end
      px.rgb   = {r, g, b};
      px.hue   = HUE_W'(hue);
      px.sat   = CHAN_W'(sat);
      px.light = CHAN_W'((sum + 1) >> 1);
      return px;
   endfunction

   always @(posedge clock) begin : watch
      hsl_pixel_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_hsl_q.size() == 0) begin
               report_failure($sformatf("result hue %0d sat %0d light %0d with no pixel",
                                        rsp_hue, rsp_saturation, rsp_lightness));
            end else begin
               want = expected_hsl_q.pop_front();
               if (rsp_hue !== want.hue)
                  report_failure($sformatf("rgb %06h: hue %0d, expected %0d",
                                           want.rgb, rsp_hue, want.hue));
               if (rsp_saturation !== want.sat)
                  report_failure($sformatf("rgb %06h: saturation %0d, expected %0d",
                                           want.rgb, rsp_saturation, want.sat));
               if (rsp_lightness !== want.light)
                  report_failure($sformatf("rgb %06h: lightness %0d, expected %0d",
                                           want.rgb, rsp_lightness, want.light));
            end
         end
         if (req_valid && req_ready)
            expected_hsl_q.push_back(hsl_of_rgb(req_red, req_green, req_blue));
      end
      pending_n <= expected_hsl_q.size();
   end

endmodule

FILE: tb/sv/testbench.sv
// Top of the RGB to HSL converter testbench: clock, reset, pixel stimulus and verdict.
// Depends on rgbhsl_pkg, rgb_to_hsl_convert and rgbhsl_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rgbhsl_pkg::*;

   // The slowest correct run puts the longest gap, the longest stall and the
   // pipeline latency in series for each pixel. The limit is many times that.
   localparam int RANDOM_PIXELS = 500;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int MAX_GAP       = 16;
   localparam int NUM_DIRECTED  = 24;

   // Directed pixels as {red, green, blue}. They cover black, white and grey, the
   // primaries, every tie for the maximum, the wrap of a negative hue, the smallest
   // and largest deltas, and both sides of the saturation denominator switch.
   localparam logic [3*CHAN_W-1:0] DIRECTED_RGB [NUM_DIRECTED] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
      24'hFF0000, 24'h00FF00, 24'h0000FF,
      24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
      24'hFF0080, 24'hFF0001, 24'hFE00FF,
      24'h010000, 24'hFFFEFE, 24'hFF0101, 24'hFE0000, 24'h80007F,
      24'hFFC864, 24'h643200, 24'h00FF01, 24'h0100FF, 24'h7F8081, 24'hC0A0E0
   };

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [CHAN_W-1:0] req_red        = '0;
   logic [CHAN_W-1:0] req_green      = '0;
   logic [CHAN_W-1:0] req_blue       = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic [HUE_W-1:0]  rsp_hue;
   logic [CHAN_W-1:0] rsp_saturation;
   logic [CHAN_W-1:0] rsp_lightness;
   int                fail_count;
   int                pending_count;
   int                cycle_count    = 0;

   rgb_to_hsl_convert DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_lightness  (rsp_lightness)
   );

   rgbhsl_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_lightness  (rsp_lightness),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The run is cut off if it hangs, for instance when a result never comes.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Each side keeps its own burst flag. While it is set the side does not idle at
   // all, so back-to-back transactions happen; otherwise it draws a gap per item.
   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;

   // Sends one pixel. Valid is lowered only when a gap is drawn, so a valid that
   // stays high for the next pixel never gets two assignments in one time step.
   // The task returns at the edge where the transaction is accepted.
   task automatic send_pixel(input logic [3*CHAN_W-1:0] rgb);
      int gap;
      if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
      gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_red, req_green, req_blue} <= rgb;
      do @(posedge clock); while (!req_ready);
   endtask

   // Holds the sender off until every outstanding result has been taken. It always
   // waits on the clock, so valid is never lowered and raised in the same step.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Receiver: before each result it stalls for a drawn number of cycles, then
   // holds ready high until a transaction completes.
   initial begin : receiver
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
         stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      logic [CHAN_W-1:0] hi, lo, r, g, b;
      int                kind;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_RGB[i]) send_pixel(DIRECTED_RGB[i]);
      wait_for_drain();

      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         // Besides the fixed pause halfway, the sender now and then lets the
         // pipeline run completely empty before it goes on.
         if (i == RANDOM_PIXELS / 2 || $urandom_range(0, 99) == 0) wait_for_drain();
         kind = $urandom_range(0, 9);
         r = CHAN_W'($urandom);
         g = CHAN_W'($urandom);
         b = CHAN_W'($urandom);
         case (kind)
            0: begin
               // Grey pixel: every channel the same.
               g = r;
               b = r;
            end
            1: begin
               // Two channels share the maximum; the third lies below them.
               hi = CHAN_W'($urandom_range(1, 255));
               lo = CHAN_W'($urandom_range(0, int'(hi) - 1));
               case ($urandom_range(0, 2))
                  0: {r, g, b} = {hi, hi, lo};
                  1: {r, g, b} = {lo, hi, hi};
                  default: {r, g, b} = {hi, lo, hi};
               endcase
            end
            2: begin
               // Channels near the ends of their range, where the saturation
               // denominator gets small.
               if ($urandom_range(0, 1) != 0) r = $urandom_range(0, 1) ? 8'd255 : 8'd254;
               else r = $urandom_range(0, 1) ? 8'd0 : 8'd1;
               if ($urandom_range(0, 1) != 0) g = $urandom_range(0, 1) ? 8'd255 : 8'd254;
               else g = $urandom_range(0, 1) ? 8'd0 : 8'd1;
               if ($urandom_range(0, 1) != 0) b = $urandom_range(0, 1) ? 8'd255 : 8'd254;
               else b = $urandom_range(0, 1) ? 8'd0 : 8'd1;
            end
            3: begin
               // Small delta around a random level.
               g = r + 8'($urandom_range(0, 2));
               b = r - 8'($urandom_range(0, 2));
            end
            default: ;
         endcase
         send_pixel({r, g, b});
      end
      req_valid <= 1'b0;

      // Let the last results drain, then give the pipeline time to show anything
      // left over before the verdict. The first edge lets the count take in the
      // last accepted pixel.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: rgb_to_hsl_convert.f
rtl/rgbhsl_pkg.sv
rtl/rgbhsl_front.sv
rtl/rgbhsl_div.sv
rtl/rgbhsl_back.sv
rtl/rgb_to_hsl_convert.sv
tb/sv/rgbhsl_checker.sv
tb/sv/testbench.sv
